// ----- rtl/lwta_pkg.sv -----
// lwta_pkg: shared types and constants of the leaky winner-take-all selector
// holds the request struct of the shared multiply-accumulate unit and the register map
// no dependencies
`default_nettype none

package lwta_pkg;

	// register map of the configuration channel
	localparam int unsigned CFG_IDX_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_REST       = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEAK       = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COMP_GAIN  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER      = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DELAY      = 4'd7;

	// register reset values
	localparam logic [63:0] RST_REST       = 64'h0000_0000_0000_0000;
	localparam logic [63:0] RST_LEAK       = 64'h0000_0000_0000_0000;
	localparam logic [63:0] RST_DRIVE_GAIN = 64'h1010_1010_1010_1010;
	localparam logic [63:0] RST_COMP_GAIN  = 64'h0000_0000_0000_0000;
	localparam logic [63:0] RST_LOWER      = 64'h8080_8080_8080_8080;
	localparam logic [63:0] RST_UPPER      = 64'h7F7F_7F7F_7F7F_7F7F;
	localparam logic [63:0] RST_HOLD       = 64'h0000_0000_0000_0000;
	localparam logic [7:0]  RST_DELAY      = 8'h00;

	// plain product add, or leak toward a rest level
	typedef enum logic {
		MAC_PROD,
		MAC_LEAK
	} mac_op_t;

	// product mode: acc + lvl * coef
	// leak mode:    acc + floor(((lvl << 4) - acc) * coef / 256)
	typedef struct packed {
		mac_op_t    op;
		logic [7:0] lvl;
		logic [8:0] coef;
	} mac_req_t;

endpackage

`default_nettype wire

// ----- rtl/lwta_mac.sv -----
// lwta_mac: shared multiply-accumulate unit with saturation to the activation width
// depends on lwta_pkg (mac_req_t, mac_op_t)
`default_nettype none

module lwta_mac #(
	parameter int unsigned ACT_WIDTH = 16
) (
	input  lwta_pkg::mac_req_t           req,
	input  logic signed [ACT_WIDTH-1:0]  acc,
	output logic signed [ACT_WIDTH-1:0]  res
);
	import lwta_pkg::*;

	localparam int unsigned DW = ACT_WIDTH + 1;
	localparam int unsigned PW = DW + 9;
	localparam int unsigned SW = PW + 1;

	localparam logic signed [SW-1:0] SAT_MAX = SW'((64'sd1 <<< (ACT_WIDTH - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SAT_MIN = -SAT_MAX - SW'(1);

	logic signed [DW-1:0] diff;
	logic signed [DW-1:0] mul_a;
	logic signed [8:0]    mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] term;
	logic signed [SW-1:0] sum;

	always_comb begin
		// rest level in q12.4 minus the current activation
		diff  = DW'($signed({req.lvl, 4'b0000})) - DW'(acc);
		mul_a = (req.op == MAC_LEAK) ? diff : DW'($signed(req.lvl));
		mul_b = $signed(req.coef);
		prod  = PW'(mul_a) * PW'(mul_b);
		// arithmetic shift rounds toward minus infinity
		term  = (req.op == MAC_LEAK) ? (prod >>> 8) : prod;
		sum   = SW'(term) + SW'(acc);
		if (sum > SAT_MAX) begin
			res = ACT_WIDTH'(SAT_MAX);
		end else if (sum < SAT_MIN) begin
			res = ACT_WIDTH'(SAT_MIN);
		end else begin
			res = sum[ACT_WIDTH-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/leaky_winner_take_all_selector.sv -----
// leaky_winner_take_all_selector: top level, config registers, sequencer and output register
// depends on lwta_pkg and lwta_mac
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata: drive_levels, completion_levels
//  m_*      out  m_tvalid/m_tready  tdata: trigger_mask, activations; tuser: winner, changed
//  cfg_*    in   cfg_valid/ready    cfg_index (register number), cfg_data
//
//  a tick runs as an accept step, an expiry step, three passes per action through the
//  single multiply-accumulate unit (drive, completion, leak), one argmax-and-clip pass
//  per action and a decide step
//  s_tready is high only while the sequencer is idle
//  the decide cycle waits while the output register still holds an untaken beat
//  reset clears activations, winner, trigger mask and countdown; no clearing pass
//  cfg_ready is always high; the user writes registers while no tick is in flight, unguarded
`default_nettype none

module leaky_winner_take_all_selector #(
	parameter int unsigned NUM_ACTIONS = 8,
	parameter int unsigned ACT_WIDTH   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input beat
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [127:0]                      s_tdata,   // drive_levels, completion_levels
	// result beat
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [135:0]                      m_tdata,   // trigger_mask, act_low, act_high
	output logic [3:0]                        m_tuser,   // winner, winner_changed
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lwta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [63:0]                       cfg_data
);
	import lwta_pkg::*;

	localparam int unsigned IW = $clog2(NUM_ACTIONS);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ACTIONS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPIRE,
		ST_DRIVE,
		ST_COMP,
		ST_LEAK,
		ST_SCAN,
		ST_DECIDE
	} state_t;

	// lane i of a packed byte register
	function automatic logic [7:0] lane8(input logic [63:0] w, input logic [2:0] i);
		return w[{i, 3'b000} +: 8];
	endfunction

	state_t state_q;
	logic [IW-1:0] idx_q;

	// configuration
	logic [63:0] rest_q, leak_q, dgain_q, cgain_q, lower_q, upper_q, hold_q;

	// tick state
	logic signed [ACT_WIDTH-1:0] act_q [NUM_ACTIONS];
	logic                        wvalid_q;
	logic [IW-1:0]               win_q;
	logic [7:0]                  cnt_q;
	logic [7:0]                  trig_q;

	// argmax scan
	logic [IW-1:0]               best_q;
	logic signed [ACT_WIDTH-1:0] best_val_q;

	// latched input beat
	logic [63:0] drive_q, comp_q;

	// output register
	logic         m_tvalid_q;
	logic [135:0] m_tdata_q;
	logic [3:0]   m_tuser_q;

	// datapath
	logic [IW-1:0]               sel;
	logic [2:0]                  sel3;
	logic signed [ACT_WIDTH-1:0] acc;
	mac_req_t                    req;
	logic signed [ACT_WIDTH-1:0] mac_res;
	logic signed [ACT_WIDTH-1:0] lo_v, hi_v, clip_lo, clip_v;
	logic                        take_best;
	logic                        out_free;
	logic                        load_out;
	logic                        changed;
	logic [7:0]                  onehot;
	logic [7:0]                  trig_new;
	logic [15:0]                 lane_out [8];

	// the expiry step works on the held winner, every other step on the running index
	always_comb begin
		sel  = (state_q == ST_EXPIRE) ? win_q : idx_q;
		sel3 = 3'(sel);
		acc  = act_q[sel];
	end

	always_comb begin
		case (state_q)
			ST_EXPIRE: req = '{op: MAC_PROD, lvl: lane8(cgain_q, sel3), coef: 9'sd16};
			ST_DRIVE:  req = '{op: MAC_PROD, lvl: lane8(drive_q, sel3),
					coef: 9'($signed(lane8(dgain_q, sel3)))};
			ST_COMP:   req = '{op: MAC_PROD, lvl: lane8(comp_q, sel3),
					coef: 9'($signed(lane8(cgain_q, sel3)))};
			ST_LEAK:   req = '{op: MAC_LEAK, lvl: lane8(rest_q, sel3),
					coef: {1'b0, lane8(leak_q, sel3)}};
			default:   req = '{op: MAC_PROD, lvl: 8'h00, coef: 9'h000};
		endcase
	end

	lwta_mac #(
		.ACT_WIDTH(ACT_WIDTH)
	) u_mac (
		.req(req),
		.acc(acc),
		.res(mac_res)
	);

	// clip: lower limit first, upper limit wins when the two cross
	always_comb begin
		lo_v      = ACT_WIDTH'($signed({lane8(lower_q, sel3), 4'b0000}));
		hi_v      = ACT_WIDTH'($signed({lane8(upper_q, sel3), 4'b0000}));
		clip_lo   = (acc < lo_v) ? lo_v : acc;
		clip_v    = (clip_lo > hi_v) ? hi_v : clip_lo;
		// argmax looks at the unclipped value, lowest index on ties
		take_best = (idx_q == '0) || (acc > best_val_q);
	end

	// winner decision and output load
	always_comb begin
		out_free = !m_tvalid_q || m_tready;
		load_out = (state_q == ST_DECIDE) && out_free;
		changed  = !wvalid_q || (win_q != best_q);
		onehot   = 8'd1 << 3'(best_q);
		trig_new = changed ? onehot : trig_q;
	end

	// output lanes, actions beyond NUM_ACTIONS read zero
	for (genvar j = 0; j < 8; j++) begin : g_lane
		if (j < NUM_ACTIONS) begin : g_used
			assign lane_out[j] = 16'($signed(act_q[j]));
		end else begin : g_unused
			assign lane_out[j] = 16'h0000;
		end
	end

	// sequencer, configuration and tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			rest_q     <= RST_REST;
			leak_q     <= RST_LEAK;
			dgain_q    <= RST_DRIVE_GAIN;
			cgain_q    <= RST_COMP_GAIN;
			lower_q    <= RST_LOWER;
			upper_q    <= RST_UPPER;
			hold_q     <= RST_HOLD;
			for (int k = 0; k < NUM_ACTIONS; k++) begin
				act_q[k] <= '0;
			end
			wvalid_q   <= 1'b0;
			win_q      <= '0;
			cnt_q      <= RST_DELAY;
			trig_q     <= 8'h00;
			best_q     <= '0;
			best_val_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (s_tvalid) begin
						state_q <= ST_EXPIRE;
					end
				end
				ST_EXPIRE: begin
					// countdown parks at zero; expiry hands the winner its completion bias
					// the dropped winner still counts as the previous one for the change test,
					// and every tick ends with a valid winner again
					if (cnt_q != 8'd0) begin
						cnt_q <= cnt_q - 8'd1;
						if (cnt_q == 8'd1 && wvalid_q) begin
							act_q[sel] <= mac_res;
						end
					end
					state_q <= ST_DRIVE;
				end
				ST_DRIVE: begin
					act_q[sel] <= mac_res;
					state_q    <= ST_COMP;
				end
				ST_COMP: begin
					act_q[sel] <= mac_res;
					state_q    <= ST_LEAK;
				end
				ST_LEAK: begin
					act_q[sel] <= mac_res;
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end else begin
						idx_q   <= idx_q + IW'(1);
						state_q <= ST_DRIVE;
					end
				end
				ST_SCAN: begin
					act_q[sel] <= clip_v;
					if (take_best) begin
						best_q     <= idx_q;
						best_val_q <= acc;
					end
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= ST_DECIDE;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						wvalid_q <= 1'b1;
						win_q    <= best_q;
						if (changed) begin
							trig_q <= onehot;
							cnt_q  <= lane8(hold_q, 3'(best_q));
						end
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_valid) begin
				case (cfg_index)
					REG_REST:       rest_q  <= cfg_data;
					REG_LEAK:       leak_q  <= cfg_data;
					REG_DRIVE_GAIN: dgain_q <= cfg_data;
					REG_COMP_GAIN:  cgain_q <= cfg_data;
					REG_LOWER:      lower_q <= cfg_data;
					REG_UPPER:      upper_q <= cfg_data;
					REG_HOLD:       hold_q  <= cfg_data;
					REG_DELAY:      cnt_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			drive_q <= s_tdata[63:0];
			comp_q  <= s_tdata[127:64];
		end
		if (load_out) begin
			m_tdata_q <= {lane_out[7], lane_out[6], lane_out[5], lane_out[4],
				lane_out[3], lane_out[2], lane_out[1], lane_out[0], trig_new};
			m_tuser_q <= {changed, 3'(best_q)};
		end
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

endmodule

`default_nettype wire

// ----- rtl/lwta_checker.sv -----
// lwta_checker: port-level assertions for the leaky winner-take-all selector
// bound to leaky_winner_take_all_selector; no package dependency
`default_nettype none

module lwta_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [135:0] m_tdata,
	input  logic [3:0]   m_tuser
);

	// one tick at a time: an accepted beat closes the input side
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a tick was in flight");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed under stall");

	// every result carries a one-hot trigger mask
	a_trig_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot(m_tdata[7:0]))
		else $error("trigger mask not one-hot");

	// on a change of winner the trigger mask points at the new winner
	a_trig_winner: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3] |-> m_tdata[7:0] == (8'd1 << m_tuser[2:0]))
		else $error("trigger mask does not match new winner");

endmodule

bind leaky_winner_take_all_selector lwta_checker u_lwta_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

`default_nettype wire

// ----- tb/tb_leaky_winner_take_all_selector.sv -----
`timescale 1ns / 100ps
// tb_leaky_winner_take_all_selector: self-checking bench for the leaky winner-take-all selector
// a directed step list, then randomized register phases and ticks, all checked per beat
// depends on lwta_pkg and the leaky_winner_take_all_selector rtl

module tb_leaky_winner_take_all_selector;
	import lwta_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 600000;
	localparam int unsigned RANDOM_TICKS    = 1700;
	// highest index of the register channel, decodes to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;

	// one result beat, split into its fields
	typedef struct packed {
		logic [2:0]  winner;
		logic        changed;
		logic [7:0]  trig;
		logic [63:0] act_lo;
		logic [63:0] act_hi;
	} tick_result_t;

	// a directed step is either a register write or a tick
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [63:0]          data;   // register value, or drive levels of a tick
		logic [63:0]          comp;
		bit                   known;  // expected beat typed in below
		tick_result_t         want;
	} step_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [127:0]         s_tdata   = '0;   // drive_levels, completion_levels
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [135:0]         m_tdata;          // trigger_mask, act_low, act_high
	logic [3:0]           m_tuser;          // winner, winner_changed
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data  = '0;

	int unsigned  cycle_count = 0;
	int           errors      = 0;
	bit           no_idle     = 1'b0;
	tick_result_t expected_results [$];
	step_t        directed_steps [$];

	// mirror of the block: registers, activations, winner, countdown, trigger mask
	logic [63:0] reg_file [8];
	longint      act_q [8];
	bit          win_valid;
	logic [2:0]  win_idx;
	logic [7:0]  countdown;
	logic [7:0]  trig_q;

	always #4 clk = ~clk;

	leaky_winner_take_all_selector dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == WATCHDOG_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic longint lane_s(input logic [63:0] w, input int i);
		return longint'($signed(w[i*8 +: 8]));
	endfunction

	function automatic longint lane_u(input logic [63:0] w, input int i);
		return longint'(w[i*8 +: 8]);
	endfunction

	function automatic longint sat_act(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic void reset_model();
		reg_file[REG_REST]       = RST_REST;
		reg_file[REG_LEAK]       = RST_LEAK;
		reg_file[REG_DRIVE_GAIN] = RST_DRIVE_GAIN;
		reg_file[REG_COMP_GAIN]  = RST_COMP_GAIN;
		reg_file[REG_LOWER]      = RST_LOWER;
		reg_file[REG_UPPER]      = RST_UPPER;
		reg_file[REG_HOLD]       = RST_HOLD;
		reg_file[REG_DELAY]      = 64'(RST_DELAY);
		foreach (act_q[i])
			act_q[i] = 0;
		win_valid = 1'b0;
		win_idx   = '0;
		countdown = RST_DELAY;
		trig_q    = '0;
	endfunction

	// indexes past the map are dropped; a delay write also loads the countdown
	function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		if (idx <= REG_DELAY) begin
			reg_file[idx[2:0]] = data;
			if (idx == REG_DELAY)
				countdown = data[7:0];
		end
	endfunction

	// one tick of the selector: expiry, drive and completion, leak, argmax, clip
	function automatic tick_result_t compute_tick(input logic [63:0] drive, input logic [63:0] comp);
		tick_result_t r;
		longint       a, diff, lo, hi;
		int           best;
		bit           prev_valid, changed;
		logic [2:0]   prev_idx;
		prev_valid = win_valid;
		prev_idx   = win_idx;
		if (countdown != 0) begin
			countdown = countdown - 1;
			// expiry credits the held winner with its completion gain and drops it
			if (countdown == 0 && win_valid) begin
				act_q[win_idx] = sat_act(act_q[win_idx] +
					lane_s(reg_file[REG_COMP_GAIN], win_idx) * 16);
				win_valid = 1'b0;
			end
		end
		for (int i = 0; i < 8; i++) begin
			a = act_q[i];
			a = sat_act(a + lane_s(drive, i) * lane_s(reg_file[REG_DRIVE_GAIN], i));
			a = sat_act(a + lane_s(comp, i) * lane_s(reg_file[REG_COMP_GAIN], i));
			diff = lane_s(reg_file[REG_REST], i) * 16 - a;
			// arithmetic shift rounds toward minus infinity
			a = sat_act(a + ((diff * lane_u(reg_file[REG_LEAK], i)) >>> 8));
			act_q[i] = a;
		end
		// argmax on unclipped values, lowest index wins ties
		best = 0;
		for (int i = 1; i < 8; i++)
			if (act_q[i] > act_q[best])
				best = i;
		changed   = !prev_valid || prev_idx != 3'(best);
		win_valid = 1'b1;
		win_idx   = 3'(best);
		if (changed) begin
			trig_q    = 8'(1 << best);
			countdown = 8'(lane_u(reg_file[REG_HOLD], best));
		end
		// lower clip first, so the upper limit wins when the two cross
		for (int i = 0; i < 8; i++) begin
			lo = lane_s(reg_file[REG_LOWER], i) * 16;
			hi = lane_s(reg_file[REG_UPPER], i) * 16;
			a  = act_q[i];
			if (a < lo)
				a = lo;
			if (a > hi)
				a = hi;
			act_q[i] = a;
			if (i < 4)
				r.act_lo[i*16 +: 16] = 16'(a);
			else
				r.act_hi[(i-4)*16 +: 16] = 16'(a);
		end
		r.winner  = 3'(best);
		r.changed = changed;
		r.trig    = trig_q;
		return r;
	endfunction

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 11);
	endfunction

	// lanes inside [lo, hi] for three draws in eight, the rest at the corners, a single set bit or anywhere
	function automatic logic [63:0] rand_word(input logic [7:0] lo, input logic [7:0] hi);
		logic [63:0] w;
		for (int i = 0; i < 8; i++) begin
			case ($urandom_range(0, 7))
				0: w[i*8 +: 8] = 8'h80;
				1: w[i*8 +: 8] = 8'h7F;
				2: w[i*8 +: 8] = 8'hFF;
				3: w[i*8 +: 8] = 8'(1 << $urandom_range(0, 7));
				4: w[i*8 +: 8] = 8'($urandom);
				default: w[i*8 +: 8] = 8'($urandom_range(lo, hi));
			endcase
		end
		return w;
	endfunction

	function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		step_t s;
		s.is_cfg = 1'b1;
		s.idx    = idx;
		s.data   = data;
		s.comp   = '0;
		s.known  = 1'b0;
		s.want   = '0;
		directed_steps.push_back(s);
	endfunction

	function automatic void add_tick(input logic [63:0] drive, input logic [63:0] comp);
		step_t s;
		s.is_cfg = 1'b0;
		s.idx    = '0;
		s.data   = drive;
		s.comp   = comp;
		s.known  = 1'b0;
		s.want   = '0;
		directed_steps.push_back(s);
	endfunction

	function automatic void add_known(input logic [63:0] drive, input logic [63:0] comp,
			input logic [2:0] winner, input logic changed, input logic [7:0] trig,
			input logic [63:0] act_lo, input logic [63:0] act_hi);
		add_tick(drive, comp);
		directed_steps[$].known = 1'b1;
		directed_steps[$].want  = '{winner, changed, trig, act_lo, act_hi};
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// one input beat; the expectation is queued at the accepting edge
	task automatic send_tick(input logic [63:0] drive, input logic [63:0] comp,
			input bit known, input tick_result_t want);
		tick_result_t r;
		int           gap;
		gap = draw_gap();
		repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {comp, drive};
		do @(posedge clk); while (!s_tready);
		r = compute_tick(drive, comp);
		expected_results.push_back(known ? want : r);
	endtask

	// park the input side and wait for every outstanding beat
	task automatic drain();
		@(negedge clk) s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_config(idx, data);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// result side: random stall before each beat, then field-by-field check
	initial begin : result_sink
		int           stall;
		tick_result_t want;
		forever begin
			stall = draw_gap();
			repeat (stall) @(negedge clk) m_tready <= 1'b0;
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (expected_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, tdata %h tuser %h",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = expected_results.pop_front();
				compare_field("winner", 64'(want.winner), 64'(m_tuser[2:0]));
				compare_field("winner_changed", 64'(want.changed), 64'(m_tuser[3]));
				compare_field("trigger_mask", 64'(want.trig), 64'(m_tdata[7:0]));
				compare_field("activations_low", want.act_lo, m_tdata[71:8]);
				compare_field("activations_high", want.act_hi, m_tdata[135:72]);
			end
		end
	end

	initial begin : stimulus
		int          random_ticks;
		int          n;
		logic [7:0]  corner;
		logic [63:0] drive, comp;
		reset_model();

		// countdown of one runs out on the first tick, before any winner exists
		add_cfg(REG_DELAY, 64'h01);
		add_known('0, '0, 3'd0, 1'b1, 8'h01, '0, '0);
		// largest drive reaches the upper clip, the second one overshoots it
		add_known({8{8'h7F}}, '0, 3'd0, 1'b0, 8'h01, {4{16'h07F0}}, {4{16'h07F0}});
		add_known({8{8'h7F}}, '0, 3'd0, 1'b0, 8'h01, {4{16'h07F0}}, {4{16'h07F0}});
		add_known({8{8'h80}}, '0, 3'd0, 1'b0, 8'h01, {4{16'hFFF0}}, {4{16'hFFF0}});
		// a single lane pulls ahead and takes over
		add_known(64'h0000_0000_7F00_0000, '0, 3'd3, 1'b1, 8'h08,
			64'h07E0_FFF0_FFF0_FFF0, {4{16'hFFF0}});
		// hold times and completion gains: expiry of a held winner
		add_cfg(REG_HOLD, 64'h0201_0302_0104_0203);
		add_cfg(REG_COMP_GAIN, 64'h7F80_0110_F010_7F80);
		add_tick('0, {8{8'h7F}});
		add_tick(64'h0180_7F01_80FF_7F00, {8{8'h80}});
		add_tick(64'h0102_0304_0506_0708, 64'h0000_0000_0000_00FF);
		add_tick('0, '0);
		add_tick('0, '0);
		add_tick('0, '0);
		// leak toward rest levels, highest and zero rates
		add_cfg(REG_REST, 64'h7F80_0010_F0FF_017F);
		add_cfg(REG_LEAK, 64'hFF00_8001_40C0_FF10);
		add_tick('0, '0);
		add_tick({8{8'h7F}}, {8{8'h80}});
		// some lanes with the lower limit above the upper one
		add_cfg(REG_LOWER, 64'h7F7F_7F7F_0000_8080);
		add_cfg(REG_UPPER, 64'h8080_8000_7F7F_1010);
		add_tick(64'h8080_7F7F_0101_FFFF, 64'h7F00_80FF_0000_1010);
		add_tick('0, '0);
		// most negative gains and levels saturate the adds
		add_cfg(REG_DRIVE_GAIN, {8{8'h80}});
		add_cfg(REG_COMP_GAIN, {8{8'h80}});
		add_cfg(REG_UPPER, {8{8'h7F}});
		add_cfg(REG_LOWER, {8{8'h80}});
		add_cfg(REG_REST, '0);
		add_cfg(REG_LEAK, '0);
		add_tick({8{8'h80}}, {8{8'h80}});
		// longest start delay, then a write to an unmapped index
		add_cfg(REG_DELAY, 64'hFF);
		add_cfg(REG_SPARE, '1);
		add_tick('0, '0);

		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (directed_steps[k]) begin
			if (directed_steps[k].is_cfg) begin
				drain();
				write_reg(directed_steps[k].idx, directed_steps[k].data);
			end else begin
				send_tick(directed_steps[k].data, directed_steps[k].comp,
					directed_steps[k].known, directed_steps[k].want);
			end
		end

		// random phases: new register settings while idle, then a run of ticks
		random_ticks = 0;
		while (random_ticks < RANDOM_TICKS) begin
			drain();
			no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0) begin
				// corner setting: one byte value in every lane of every register but the delay
				case ($urandom_range(0, 3))
					0: corner = 8'h80;
					1: corner = 8'h7F;
					2: corner = 8'h00;
					default: corner = 8'hFF;
				endcase
				for (int r = 0; r <= int'(REG_HOLD); r++)
					write_reg(CFG_IDX_W'(r), {8{corner}});
			end else begin
				if ($urandom_range(0, 1)) write_reg(REG_REST, rand_word(8'h00, 8'hFF));
				if ($urandom_range(0, 1)) write_reg(REG_LEAK, rand_word(8'h00, 8'h40));
				if ($urandom_range(0, 1)) write_reg(REG_DRIVE_GAIN, rand_word(8'h00, 8'hFF));
				if ($urandom_range(0, 1)) write_reg(REG_COMP_GAIN, rand_word(8'h00, 8'hFF));
				if ($urandom_range(0, 1)) write_reg(REG_LOWER, rand_word(8'h80, 8'hFF));
				if ($urandom_range(0, 1)) write_reg(REG_UPPER, rand_word(8'h00, 8'h7F));
				if ($urandom_range(0, 1)) write_reg(REG_HOLD, rand_word(8'h00, 8'h05));
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_DELAY, ($urandom_range(0, 3) == 0) ?
					64'($urandom) : 64'($urandom_range(0, 8)));
			if ($urandom_range(0, 7) == 0)
				write_reg(REG_DELAY + CFG_IDX_W'($urandom_range(1, 8)),
					{$urandom, $urandom});
			n = $urandom_range(20, 120);
			repeat (n) begin
				drive = rand_word(8'h00, 8'hFF);
				comp  = ($urandom_range(0, 2) == 0) ? 64'h0 : rand_word(8'h00, 8'hFF);
				send_tick(drive, comp, 1'b0, '0);
			end
			random_ticks += n;
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
